@@ rtl/core/amcl_pkg.sv @@
// Shared types, constants and helpers for the adaptive mapping cache lookup unit.
// No dependencies; used by amcl_rem and adaptive_mapping_cache_lookup_unit.
package amcl_pkg;

    localparam int ADDR_W      = 32;
    localparam int CNT_W       = 32;
    localparam int RATE_W      = 9;
    localparam int MODE_W      = 2;
    localparam int RATE_FRAC_W = 8;                    // miss rate in 1/256 units
    localparam int PROD_W      = RATE_W + CNT_W;
    localparam int SET_COUNT   = 4;

    // remainder unit: dividend bits retired per cycle
    localparam int REM_STEPS   = 4;
    localparam int REM_ROUNDS  = ADDR_W / REM_STEPS;

    localparam logic [RATE_W-1:0] RATE_RESET = 9'd128;
    localparam logic [CNT_W-1:0]  CNT_MAX    = 32'hFFFF_FFFF;

    typedef logic [MODE_W-1:0] mode_t;

    localparam mode_t MODE_DIRECT = 2'd0;
    localparam mode_t MODE_SET4   = 2'd1;
    localparam mode_t MODE_FULL   = 2'd2;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? v : v + 1'b1;
    endfunction

    function automatic mode_t mode_advance(input mode_t m);
        return (m == MODE_FULL) ? MODE_DIRECT : mode_t'(m + 1'b1);
    endfunction

endpackage

@@ rtl/core/adaptive_mapping_cache_lookup_unit.sv @@
// Top level of the adaptive mapping cache lookup unit (directory with switchable mapping).
// Depends on amcl_pkg, amcl_ram and amcl_rem.
//
// Usage:
//   Input channel: drive address and raise start; the transfer happens at a clock edge
//   where start is high and busy is low. busy stays high until the result is out.
//   Result channel: done pulses for one cycle with hit, mode_used, mode_switched,
//   miss_count and access_count. The receiver cannot stall; take it in that cycle.
//   Config: max_miss_rate is written at any edge where max_miss_rate_we is high;
//   write it only while the block is idle. Reset value is 128.
// Flow (accept to done), with N = CACHE_SIZE:
//   direct mode first computes address mod N (remainder unit, 4 bits/cycle);
//   the scan reads one entry per cycle from the entry RAM (registered read data),
//   1 entry in direct mode, about N/4 in four-set mode, N in fully associative mode,
//   stopping at the first hit. A hit finishes once the matching read is compared.
//   A miss adds a write state and a compare state; with no free entry in a set or in
//   the full store, the remainder unit first computes the replacement offset.
//   One item in flight at a time.
// Reset: rst_n is asynchronous. After reset a clearing pass writes every entry
//   invalid; busy is high during it. Mode returns to direct, counters to zero.
module adaptive_mapping_cache_lookup_unit #(
    parameter int CACHE_SIZE = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // input channel
    input  logic                          start,
    output logic                          busy,
    input  logic [amcl_pkg::ADDR_W-1:0]   address,
    // result channel
    output logic                          done,
    output logic                          hit,
    output logic [amcl_pkg::MODE_W-1:0]   mode_used,
    output logic                          mode_switched,
    output logic [amcl_pkg::CNT_W-1:0]    miss_count,
    output logic [amcl_pkg::CNT_W-1:0]    access_count,
    // config
    input  logic                          max_miss_rate_we,
    input  logic [amcl_pkg::RATE_W-1:0]   max_miss_rate
);

    localparam int IW    = $clog2(CACHE_SIZE);      // entry index
    localparam int DW    = $clog2(CACHE_SIZE + 1);  // range bounds, can hold CACHE_SIZE
    localparam int PART  = CACHE_SIZE / amcl_pkg::SET_COUNT;
    localparam int EXTRA = CACHE_SIZE % amcl_pkg::SET_COUNT;
    localparam int EW    = amcl_pkg::ADDR_W + 1;    // entry word: {valid, address}

    typedef enum logic [6:0] {
        ST_CLEAR    = 7'b0000001,
        ST_IDLE     = 7'b0000010,
        ST_DIV_ADDR = 7'b0000100,
        ST_SCAN     = 7'b0001000,
        ST_DIV_VIC  = 7'b0010000,
        ST_WRITE    = 7'b0100000,
        ST_DECIDE   = 7'b1000000
    } state_t;

    state_t                        state_reg, state_next;
    amcl_pkg::mode_t               mode_reg, mode_next;
    logic [amcl_pkg::CNT_W-1:0]    miss_cnt_reg, miss_cnt_next;
    logic [amcl_pkg::CNT_W-1:0]    acc_cnt_reg, acc_cnt_next;
    logic [amcl_pkg::RATE_W-1:0]   rate_reg, rate_next;
    logic [IW-1:0]                 clr_idx_reg, clr_idx_next;
    logic                          chk_vld_reg, chk_vld_next;
    logic                          free_found_reg, free_found_next;

    logic [amcl_pkg::ADDR_W-1:0]   addr_reg, addr_next;
    logic [DW-1:0]                 lo_reg, lo_next;
    logic [DW-1:0]                 hi_reg, hi_next;
    logic [DW-1:0]                 span_reg, span_next;
    logic [DW-1:0]                 rd_ptr_reg, rd_ptr_next;
    logic [IW-1:0]                 chk_idx_reg, chk_idx_next;
    logic [IW-1:0]                 free_idx_reg, free_idx_next;
    logic [IW-1:0]                 victim_reg, victim_next;
    logic [amcl_pkg::PROD_W-1:0]   prod_reg, prod_next;

    logic                          done_reg, done_next;
    logic                          hit_reg, hit_next;
    amcl_pkg::mode_t               mode_out_reg, mode_out_next;
    logic                          sw_reg, sw_next;
    logic [amcl_pkg::CNT_W-1:0]    miss_out_reg, miss_out_next;
    logic [amcl_pkg::CNT_W-1:0]    acc_out_reg, acc_out_next;

    // RAM and remainder unit hookup
    logic                          ram_we, ram_re;
    logic [IW-1:0]                 ram_waddr, ram_raddr;
    logic [EW-1:0]                 ram_wdata, ram_rdata;
    logic                          rem_start, rem_done;
    logic [amcl_pkg::ADDR_W-1:0]   rem_dividend;
    logic [DW-1:0]                 rem_divisor, rem_result;

    logic                          ent_valid;
    logic [amcl_pkg::ADDR_W-1:0]   ent_addr;
    logic                          scan_last;
    logic [DW-1:0]                 set_lo;
    logic [amcl_pkg::PROD_W-1:0]   miss_scaled;

    amcl_ram #(
        .WIDTH (EW),
        .DEPTH (CACHE_SIZE)
    ) u_entry_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    amcl_rem #(
        .DW (DW)
    ) u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (rem_start),
        .dividend (rem_dividend),
        .divisor  (rem_divisor),
        .done     (rem_done),
        .result   (rem_result)
    );

    assign ent_valid   = ram_rdata[amcl_pkg::ADDR_W];
    assign ent_addr    = ram_rdata[amcl_pkg::ADDR_W-1:0];
    assign scan_last   = ((DW'(chk_idx_reg) + 1'b1) == hi_reg);
    assign set_lo      = DW'(PART * int'(address[1:0]));
    assign miss_scaled = {1'b0, miss_cnt_reg, {amcl_pkg::RATE_FRAC_W{1'b0}}};

    always_comb
    begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        miss_cnt_next   = miss_cnt_reg;
        acc_cnt_next    = acc_cnt_reg;
        rate_next       = max_miss_rate_we ? max_miss_rate : rate_reg;
        clr_idx_next    = clr_idx_reg;
        chk_vld_next    = chk_vld_reg;
        free_found_next = free_found_reg;
        addr_next       = addr_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        span_next       = span_reg;
        rd_ptr_next     = rd_ptr_reg;
        chk_idx_next    = chk_idx_reg;
        free_idx_next   = free_idx_reg;
        victim_next     = victim_reg;
        prod_next       = prod_reg;

        done_next       = 1'b0;
        hit_next        = hit_reg;
        mode_out_next   = mode_out_reg;
        sw_next         = sw_reg;
        miss_out_next   = miss_out_reg;
        acc_out_next    = acc_out_reg;

        ram_we          = 1'b0;
        ram_waddr       = victim_reg;
        ram_wdata       = {1'b1, addr_reg};
        ram_re          = 1'b0;
        ram_raddr       = rd_ptr_reg[IW-1:0];
        rem_start       = 1'b0;
        rem_dividend    = address;
        rem_divisor     = DW'(CACHE_SIZE);

        unique case (state_reg)
            ST_CLEAR:
            begin
                // post-reset sweep: every entry goes invalid
                ram_we       = 1'b1;
                ram_waddr    = clr_idx_reg;
                ram_wdata    = '0;
                clr_idx_next = clr_idx_reg + 1'b1;
                if (clr_idx_reg == IW'(CACHE_SIZE - 1))
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (start)
                begin
                    addr_next       = address;
                    acc_cnt_next    = amcl_pkg::sat_inc(acc_cnt_reg);
                    chk_vld_next    = 1'b0;
                    free_found_next = 1'b0;
                    unique case (mode_reg)
                        amcl_pkg::MODE_DIRECT:
                        begin
                            rem_start  = 1'b1;
                            state_next = ST_DIV_ADDR;
                        end
                        amcl_pkg::MODE_SET4:
                        begin
                            lo_next     = set_lo;
                            rd_ptr_next = set_lo;
                            if (address[1:0] == 2'(amcl_pkg::SET_COUNT - 1))
                            begin
                                hi_next   = DW'(CACHE_SIZE);
                                span_next = DW'(PART + EXTRA);
                            end
                            else
                            begin
                                hi_next   = set_lo + DW'(PART);
                                span_next = DW'(PART);
                            end
                            state_next = ST_SCAN;
                        end
                        default:
                        begin
                            lo_next     = '0;
                            rd_ptr_next = '0;
                            hi_next     = DW'(CACHE_SIZE);
                            span_next   = DW'(CACHE_SIZE);
                            state_next  = ST_SCAN;
                        end
                    endcase
                end
            end

            ST_DIV_ADDR:
            begin
                if (rem_done)
                begin
                    lo_next     = rem_result;
                    rd_ptr_next = rem_result;
                    hi_next     = rem_result + 1'b1;
                    state_next  = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                // issue next read while checking the previous one
                if (rd_ptr_reg < hi_reg)
                begin
                    ram_re       = 1'b1;
                    rd_ptr_next  = rd_ptr_reg + 1'b1;
                    chk_vld_next = 1'b1;
                    chk_idx_next = rd_ptr_reg[IW-1:0];
                end
                else
                begin
                    chk_vld_next = 1'b0;
                end

                if (chk_vld_reg)
                begin
                    if (ent_valid && (ent_addr == addr_reg))
                    begin
                        done_next     = 1'b1;
                        hit_next      = 1'b1;
                        mode_out_next = mode_reg;
                        sw_next       = 1'b0;
                        miss_out_next = miss_cnt_reg;
                        acc_out_next  = acc_cnt_reg;
                        state_next    = ST_IDLE;
                    end
                    else
                    begin
                        if (!free_found_reg && !ent_valid)
                        begin
                            free_found_next = 1'b1;
                            free_idx_next   = chk_idx_reg;
                        end
                        if (scan_last)
                        begin
                            if (mode_reg == amcl_pkg::MODE_DIRECT)
                            begin
                                victim_next = lo_reg[IW-1:0];
                                state_next  = ST_WRITE;
                            end
                            else if (free_found_reg)
                            begin
                                victim_next = free_idx_reg;
                                state_next  = ST_WRITE;
                            end
                            else if (!ent_valid)
                            begin
                                victim_next = chk_idx_reg;
                                state_next  = ST_WRITE;
                            end
                            else
                            begin
                                // range full: offset = access count mod range size
                                rem_start    = 1'b1;
                                rem_dividend = acc_cnt_reg;
                                rem_divisor  = span_reg;
                                state_next   = ST_DIV_VIC;
                            end
                        end
                    end
                end
            end

            ST_DIV_VIC:
            begin
                rem_dividend = acc_cnt_reg;
                rem_divisor  = span_reg;
                if (rem_done)
                begin
                    victim_next = IW'(lo_reg + rem_result);
                    state_next  = ST_WRITE;
                end
            end

            ST_WRITE:
            begin
                ram_we        = 1'b1;
                miss_cnt_next = amcl_pkg::sat_inc(miss_cnt_reg);
                prod_next     = amcl_pkg::PROD_W'(rate_reg) *
                                amcl_pkg::PROD_W'(acc_cnt_reg);
                state_next    = ST_DECIDE;
            end

            ST_DECIDE:
            begin
                done_next     = 1'b1;
                hit_next      = 1'b0;
                mode_out_next = mode_reg;
                if (miss_scaled > prod_reg)
                begin
                    mode_next     = amcl_pkg::mode_advance(mode_reg);
                    miss_cnt_next = '0;
                    acc_cnt_next  = '0;
                    sw_next       = 1'b1;
                    miss_out_next = '0;
                    acc_out_next  = '0;
                end
                else
                begin
                    sw_next       = 1'b0;
                    miss_out_next = miss_cnt_reg;
                    acc_out_next  = acc_cnt_reg;
                end
                state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            mode_reg       <= amcl_pkg::MODE_DIRECT;
            miss_cnt_reg   <= '0;
            acc_cnt_reg    <= '0;
            rate_reg       <= amcl_pkg::RATE_RESET;
            clr_idx_reg    <= '0;
            chk_vld_reg    <= 1'b0;
            free_found_reg <= 1'b0;
            done_reg       <= 1'b0;
            hit_reg        <= 1'b0;
            mode_out_reg   <= amcl_pkg::MODE_DIRECT;
            sw_reg         <= 1'b0;
            miss_out_reg   <= '0;
            acc_out_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            mode_reg       <= mode_next;
            miss_cnt_reg   <= miss_cnt_next;
            acc_cnt_reg    <= acc_cnt_next;
            rate_reg       <= rate_next;
            clr_idx_reg    <= clr_idx_next;
            chk_vld_reg    <= chk_vld_next;
            free_found_reg <= free_found_next;
            done_reg       <= done_next;
            hit_reg        <= hit_next;
            mode_out_reg   <= mode_out_next;
            sw_reg         <= sw_next;
            miss_out_reg   <= miss_out_next;
            acc_out_reg    <= acc_out_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg     <= addr_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        span_reg     <= span_next;
        rd_ptr_reg   <= rd_ptr_next;
        chk_idx_reg  <= chk_idx_next;
        free_idx_reg <= free_idx_next;
        victim_reg   <= victim_next;
        prod_reg     <= prod_next;
    end

    assign busy          = (state_reg != ST_IDLE);
    assign done          = done_reg;
    assign hit           = hit_reg;
    assign mode_used     = mode_out_reg;
    assign mode_switched = sw_reg;
    assign miss_count    = miss_out_reg;
    assign access_count  = acc_out_reg;

    // result strobe only lands once the controller is back in idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (state_reg == ST_IDLE))
        else $error("result strobe outside idle");

    // a transfer always makes the block busy next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transfer did not start work");

    // a mode switch clears both counters in the reported result
    a_switch_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (done && mode_switched) |-> ((miss_count == '0) && (access_count == '0)))
        else $error("switch reported with nonzero counters");

    // switch is only evaluated on a miss
    a_hit_no_switch: assert property (@(posedge clk) disable iff (!rst_n)
        (done && hit) |-> !mode_switched)
        else $error("switch reported on a hit");

    // remainder results only arrive while a state waits for them
    a_rem_expected: assert property (@(posedge clk) disable iff (!rst_n)
        rem_done |-> ((state_reg == ST_DIV_ADDR) || (state_reg == ST_DIV_VIC)))
        else $error("unexpected remainder result");

endmodule

@@ rtl/core/amcl_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module amcl_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ rtl/core/amcl_rem.sv @@
// Multi-cycle remainder unit: 32-bit dividend mod a narrow divisor, REM_STEPS bits a cycle.
// Depends on amcl_pkg.
module amcl_rem #(
    parameter int DW = 5
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [amcl_pkg::ADDR_W-1:0] dividend,
    input  logic [DW-1:0]              divisor,
    output logic                       done,
    output logic [DW-1:0]              result
);

    localparam int CW = (amcl_pkg::REM_ROUNDS > 1) ? $clog2(amcl_pkg::REM_ROUNDS) : 1;

    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [CW-1:0]               cnt_reg, cnt_next;
    logic [amcl_pkg::ADDR_W-1:0] dvd_reg, dvd_next;
    logic [DW-1:0]               div_reg, div_next;
    logic [DW-1:0]               rem_reg, rem_next;

    // restoring remainder, a few digits per cycle
    always_comb
    begin
        logic [DW:0]                 t;
        logic [DW-1:0]               r;
        logic [amcl_pkg::ADDR_W-1:0] q;
        r = rem_reg;
        q = dvd_reg;
        for (int k = 0; k < amcl_pkg::REM_STEPS; k++)
        begin
            t = {r, q[amcl_pkg::ADDR_W-1]};
            q = {q[amcl_pkg::ADDR_W-2:0], 1'b0};
            if (t >= {1'b0, div_reg})
            begin
                t = t - {1'b0, div_reg};
            end
            r = t[DW-1:0];
        end

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        div_next  = div_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = dividend;
            div_next  = divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            dvd_next = q;
            rem_next = r;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(amcl_pkg::REM_ROUNDS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        div_reg <= div_next;
        rem_reg <= rem_next;
    end

    assign done   = done_reg;
    assign result = rem_reg;

endmodule

@@ verif/testbench.sv @@
// Self-checking testbench for adaptive_mapping_cache_lookup_unit.
// Depends on amcl_pkg and the unit's RTL; predicts each lookup in place and
// checks every result transfer against the oldest pending prediction.
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import amcl_pkg::*;

    localparam int unsigned DIR_SIZE   = 16;
    // idle wait after draining; also covers the clearing pass
    localparam int          SETTLE     = DIR_SIZE + 24;
    localparam int          CYCLE_CAP  = 500000;
    localparam int          MAX_SHOWN  = 10;
    localparam int          RAND_PHASES = 12;

    // one predicted lookup outcome, in the order of the result ports
    typedef struct packed {
        logic             hit;
        mode_t            mode;
        logic             switched;
        logic [CNT_W-1:0] misses;
        logic [CNT_W-1:0] accesses;
    } lookup_result_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic [ADDR_W-1:0]   address = '0;
    logic                done;
    logic                hit;
    logic [MODE_W-1:0]   mode_used;
    logic                mode_switched;
    logic [CNT_W-1:0]    miss_count;
    logic [CNT_W-1:0]    access_count;
    logic                max_miss_rate_we = 1'b0;
    logic [RATE_W-1:0]   max_miss_rate = '0;

    adaptive_mapping_cache_lookup_unit #(
        .CACHE_SIZE (DIR_SIZE)
    ) dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .address          (address),
        .done             (done),
        .hit              (hit),
        .mode_used        (mode_used),
        .mode_switched    (mode_switched),
        .miss_count       (miss_count),
        .access_count     (access_count),
        .max_miss_rate_we (max_miss_rate_we),
        .max_miss_rate    (max_miss_rate)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Shadow copy of the directory: entries, mapping mode, counters and
    // the miss-rate limit as last written.
    // ------------------------------------------------------------------
    logic [ADDR_W-1:0] dir_addr [DIR_SIZE];
    bit                dir_valid [DIR_SIZE];
    mode_t             map_mode = MODE_DIRECT;
    logic [CNT_W-1:0]  miss_total = '0;
    logic [CNT_W-1:0]  access_total = '0;
    logic [RATE_W-1:0] rate_limit = RATE_RESET;

    logic [ADDR_W-1:0]  addrs_pending [$];   // addresses waiting for a transfer
    lookup_result_t     lookups_due [$];     // predictions waiting for done

    int  gap_left = 0;
    int  next_gap;
    bit  idle_on = 1'b1;
    int  mismatch_count = 0;
    int  cycle_count = 0;

    // Lookup of one address: access count first, then the search of the
    // range picked by the mode, then on a miss the fill and the rate test.
    function automatic lookup_result_t predict_lookup(input logic [ADDR_W-1:0] a);
        int unsigned    lo;
        int unsigned    hi;
        int unsigned    victim;
        int unsigned    span;
        int unsigned    set_idx;
        int unsigned    part;
        bit             matched;
        bit             have_free;
        lookup_result_t r;
        matched   = 1'b0;
        have_free = 1'b0;
        victim    = 0;
        r.mode     = map_mode;
        r.switched = 1'b0;
        if (access_total != '1)
            access_total = access_total + 1'b1;
        case (map_mode)
            MODE_DIRECT:
            begin
                lo = a % DIR_SIZE;
                hi = lo + 1;
            end
            MODE_SET4:
            begin
                set_idx = a % SET_COUNT;
                part    = DIR_SIZE / SET_COUNT;
                lo      = set_idx * part;
                hi      = lo + part;
                // the last set also takes the leftover entries
                if (set_idx == SET_COUNT - 1)
                    hi += DIR_SIZE % SET_COUNT;
            end
            default:
            begin
                lo = 0;
                hi = DIR_SIZE;
            end
        endcase
        if (hi > DIR_SIZE)
            hi = DIR_SIZE;
        for (int unsigned i = lo; i < hi; i++)
        begin
            if (dir_valid[i] && dir_addr[i] == a)
            begin
                matched = 1'b1;
                break;
            end
            if (!have_free && !dir_valid[i])
            begin
                victim    = i;
                have_free = 1'b1;
            end
        end
        if (!matched)
        begin
            if (map_mode == MODE_DIRECT)
                victim = lo;
            else if (!have_free)
            begin
                // range full: rotate by the access count
                span   = hi - lo;
                victim = lo + ((span != 0) ? access_total % span : 0);
            end
            if (victim >= DIR_SIZE)
                victim = 0;
            if (miss_total != '1)
                miss_total = miss_total + 1'b1;
            dir_addr[victim]  = a;
            dir_valid[victim] = 1'b1;
            if (64'(miss_total) * 64'd256 > 64'(rate_limit) * 64'(access_total))
            begin
                case (map_mode)
                    MODE_DIRECT: map_mode = MODE_SET4;
                    MODE_SET4:   map_mode = MODE_FULL;
                    default:     map_mode = MODE_DIRECT;
                endcase
                miss_total   = '0;
                access_total = '0;
                r.switched   = 1'b1;
            end
        end
        r.hit      = matched;
        r.misses   = miss_total;
        r.accesses = access_total;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Driver: a transfer happens at an edge with start high and busy low.
    // The prediction is made at that edge. After each transfer an idle gap
    // is drawn at random; idle_on flips now and then so that there are
    // back-to-back stretches where start simply stays high.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start    <= 1'b0;
            address  <= '0;
            gap_left <= 0;
        end
        else if (start && !busy)
        begin
            lookups_due.push_back(predict_lookup(address));
            if ($urandom_range(0, 39) == 0)
                idle_on = !idle_on;
            next_gap = idle_on ? $urandom_range(0, 17) : 0;
            if (next_gap == 0 && addrs_pending.size() != 0)
                address <= addrs_pending.pop_front();   // start stays high
            else
            begin
                start    <= 1'b0;
                gap_left <= next_gap;
            end
        end
        else if (!start)
        begin
            if (gap_left != 0)
                gap_left <= gap_left - 1;
            else if (addrs_pending.size() != 0)
            begin
                start   <= 1'b1;
                address <= addrs_pending.pop_front();
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: done marks a result for exactly one cycle; the receiver
    // cannot hold it off, so every done edge is a transfer.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        lookup_result_t want;
        if (rst_n && done)
        begin
            if (lookups_due.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_SHOWN)
                    $display("%0t: result with nothing outstanding: hit=%0b mode=%0d sw=%0b misses=%0d accesses=%0d",
                             $realtime, hit, mode_used, mode_switched, miss_count, access_count);
            end
            else
            begin
                want = lookups_due.pop_front();
                if (hit !== want.hit || mode_used !== want.mode ||
                    mode_switched !== want.switched ||
                    miss_count !== want.misses || access_count !== want.accesses)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_SHOWN)
                    begin
                        $display("%0t: mismatch exp hit=%0b mode=%0d sw=%0b misses=%0d accesses=%0d",
                                 $realtime, want.hit, want.mode, want.switched,
                                 want.misses, want.accesses);
                        $display("%0t:          got hit=%0b mode=%0d sw=%0b misses=%0d accesses=%0d",
                                 $realtime, hit, mode_used, mode_switched,
                                 miss_count, access_count);
                    end
                end
            end
        end
    end

    // hard stop if the block hangs
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_CAP)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Wait until every queued address is transferred and every result is
    // back, then let the block settle before touching the limit register.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (addrs_pending.size() != 0 || start || lookups_due.size() != 0 || busy);
        repeat (SETTLE) @(posedge clk);
    endtask

    // The limit register is only written while the block is idle.
    task automatic set_limit(input logic [RATE_W-1:0] v);
        @(posedge clk);
        max_miss_rate_we <= 1'b1;
        max_miss_rate    <= v;
        rate_limit        = v;
        @(posedge clk);
        max_miss_rate_we <= 1'b0;
    endtask

    // Random phase: mostly a small working set so that hits occur, some
    // aliases at multiples of 16 apart (same direct slot, same set), some fully random.
    task automatic queue_random_phase(input int count);
        logic [ADDR_W-1:0] pool [$];
        logic [ADDR_W-1:0] base;
        logic [ADDR_W-1:0] a;
        int                pool_n;
        int                pick;
        pool_n = $urandom_range(4, 24);
        base   = $urandom();
        for (int i = 0; i < pool_n; i++)
        begin
            if ($urandom_range(0, 1) == 0)
                pool.push_back($urandom());
            else
                pool.push_back(base + ADDR_W'(i * $urandom_range(1, 5)));
        end
        for (int k = 0; k < count; k++)
        begin
            pick = $urandom_range(0, 99);
            a    = pool[$urandom_range(0, pool_n - 1)];
            if (pick >= 85)
                a = $urandom();
            else if (pick >= 70)
                a = a + ADDR_W'($urandom_range(1, 8) * DIR_SIZE);
            addrs_pending.push_back(a);
        end
    endtask

    initial
    begin
        int rate_menu [6];
        rate_menu = '{0, 256, 1, 255, 128, 64};

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        wait_drained();                      // covers the clearing pass

        // Direct mode under a limit that is never exceeded: slot hits,
        // conflicts at slot 0, both address extremes at slot 15.
        set_limit(9'd256);
        @(negedge clk);
        addrs_pending = '{32'h0000_0000, 32'h0000_0000, 32'h0000_0010, 32'h0000_0000,
                          32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_000F};
        wait_drained();

        // zero limit: the first miss switches direct -> four-set
        set_limit(9'd0);
        @(negedge clk);
        addrs_pending = '{32'h1234_5678};
        wait_drained();

        // four-set: fill the last set, hit an entry left by direct mode,
        // then a miss with the set full forces the rotating victim
        set_limit(9'd256);
        @(negedge clk);
        addrs_pending = '{32'h0000_0003, 32'h0000_0007, 32'h0000_000B,
                          32'h8000_000F, 32'h0000_0013};
        wait_drained();

        // zero limit: four-set -> fully associative
        set_limit(9'd0);
        @(negedge clk);
        addrs_pending = '{32'hDEAD_BEEF};
        wait_drained();

        // fully associative: fill the whole store, hit, then evict
        set_limit(9'd256);
        @(negedge clk);
        addrs_pending = '{32'hA000_0000, 32'hA000_0001, 32'hA000_0002, 32'hA000_0003,
                          32'hA000_0004, 32'hA000_0005, 32'hA000_0006, 32'hA000_0007,
                          32'hA000_0003, 32'h1234_5678, 32'hA000_0008, 32'hA000_0009,
                          32'hA000_000A};
        wait_drained();

        // zero limit: fully associative wraps back to direct
        set_limit(9'd0);
        @(negedge clk);
        addrs_pending = '{32'h5555_AAAA};
        wait_drained();

        // random phases, limit extremes first, then random limits
        for (int p = 0; p < RAND_PHASES; p++)
        begin
            if (p < 6)
                set_limit(RATE_W'(rate_menu[p]));
            else
                set_limit(RATE_W'($urandom_range(0, 256)));
            @(negedge clk);
            queue_random_phase($urandom_range(60, 90));
            wait_drained();
        end

        if (mismatch_count == 0 && lookups_due.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
